// ----- rtl/rlcd_pkg.sv -----
// Shared types and register codes for the ray and line closest-distance core.
// No dependencies; used by rlcd_div and ray_line_closest_distance_core.
package rlcd_pkg;

  // Width of the configuration register index
  localparam int unsigned CFG_IDX_W = 3;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_AXIS_ORIGIN_X = 3'd0,
    REG_AXIS_ORIGIN_Y = 3'd1,
    REG_AXIS_ORIGIN_Z = 3'd2,
    REG_AXIS_DIR_X    = 3'd3,
    REG_AXIS_DIR_Y    = 3'd4,
    REG_AXIS_DIR_Z    = 3'd5,
    REG_PARALLEL_EPS  = 3'd6
  } cfg_reg_e;

  // Status that travels with a quotient out of the divider
  typedef struct packed {
    logic ovf;  // quotient saturated
    logic neg;  // quotient is below zero after rounding
  } div_stat_t;

endpackage

// ----- rtl/rlcd_div.sv -----
// Pipelined fixed-point divider, one quotient bit per stage, rounded and saturated.
// Depends on rlcd_pkg (div_stat_t).
module rlcd_div #(
  parameter int unsigned COORD_WIDTH = 32,
  parameter int unsigned FRAC_BITS   = 16
) (
  input  logic                          clk_i,
  input  logic                          en_i,
  input  logic signed [COORD_WIDTH-1:0] num_i,
  input  logic signed [COORD_WIDTH-1:0] den_i,
  output logic signed [COORD_WIDTH-1:0] quot_o,
  output rlcd_pkg::div_stat_t           stat_o
);

  localparam int unsigned W  = COORD_WIDTH;
  localparam int unsigned F  = FRAC_BITS;
  localparam int unsigned NQ = W + F;

  // Combined dividend / quotient shift word, partial remainder, divisor, sign
  logic [NQ-1:0] nq_q  [NQ+1];
  logic [W-1:0]  rem_q [NQ+1];
  logic [W-1:0]  d_q   [NQ+1];
  logic          neg_q [NQ+1];

  logic [W-1:0] num_mag;
  logic [W-1:0] den_mag;

  // Entry stage: magnitudes and result sign
  assign num_mag = num_i[W-1] ? (~num_i + W'(1)) : num_i;
  assign den_mag = den_i[W-1] ? (~den_i + W'(1)) : den_i;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      nq_q[0]  <= {num_mag, {F{1'b0}}};
      rem_q[0] <= '0;
      d_q[0]   <= den_mag;
      neg_q[0] <= num_i[W-1] ^ den_i[W-1];
    end
  end

  // Restoring steps, most significant quotient bit first
  genvar i;
  for (i = 1; i <= NQ; i++) begin : g_step
    logic [W:0] rem2;
    logic       ge;
    assign rem2 = {rem_q[i-1], nq_q[i-1][NQ-1]};
    assign ge   = rem2 >= {1'b0, d_q[i-1]};
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[i] <= ge ? W'(rem2 - {1'b0, d_q[i-1]}) : rem2[W-1:0];
        nq_q[i]  <= {nq_q[i-1][NQ-2:0], ge};
        d_q[i]   <= d_q[i-1];
        neg_q[i] <= neg_q[i-1];
      end
    end
  end

  // Round half away from zero, then saturate to the signed word
  logic          rnd;
  logic [NQ:0]   q_rnd;
  logic [NQ:0]   q_lim;
  logic [NQ:0]   q_mag;
  logic [W-1:0]  quot_d;
  logic          ovf_d;

  always_comb begin
    rnd    = {rem_q[NQ], 1'b0} >= {1'b0, d_q[NQ]};
    q_rnd  = {1'b0, nq_q[NQ]} + (NQ+1)'(rnd);
    q_lim  = neg_q[NQ] ? ((NQ+1)'(1) << (W-1)) : (((NQ+1)'(1) << (W-1)) - (NQ+1)'(1));
    ovf_d  = q_rnd > q_lim;
    q_mag  = ovf_d ? q_lim : q_rnd;
    quot_d = neg_q[NQ] ? W'(~q_mag + (NQ+1)'(1)) : W'(q_mag);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      quot_o     <= quot_d;
      stat_o.ovf <= ovf_d;
      stat_o.neg <= quot_d[W-1];
    end
  end

endmodule

// ----- rtl/rlcd_sqrt.sv -----
// Pipelined integer square root, one root bit per stage, rounded to nearest.
// No package dependencies.
module rlcd_sqrt #(
  parameter int unsigned COORD_WIDTH = 32
) (
  input  logic                     clk_i,
  input  logic                     en_i,
  input  logic [2*COORD_WIDTH-1:0] sq_i,
  output logic [COORD_WIDTH-2:0]   dist_o,
  output logic                     sat_o
);

  localparam int unsigned W = COORD_WIDTH;

  // Remainder sq - root^2 and partial root after each step
  logic [2*W-1:0] rem_q  [W];
  logic [W-1:0]   root_q [W];

  genvar i;
  for (i = 0; i < W; i++) begin : g_step
    localparam int unsigned K = W - 1 - i;
    logic [2*W-1:0] rem_in;
    logic [W-1:0]   root_in;
    logic [2*W:0]   trial;
    logic           ge;
    if (i == 0) begin : g_first
      assign rem_in  = sq_i;
      assign root_in = '0;
    end else begin : g_next
      assign rem_in  = rem_q[i-1];
      assign root_in = root_q[i-1];
    end
    // (root + 2^K)^2 - root^2 = root * 2^(K+1) + 4^K
    assign trial = ((2*W+1)'(root_in) << (K + 1)) | ((2*W+1)'(1) << (2 * K));
    assign ge    = {1'b0, rem_in} >= trial;
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[i]  <= ge ? (rem_in - trial[2*W-1:0]) : rem_in;
        root_q[i] <= ge ? (root_in | (W'(1) << K)) : root_in;
      end
    end
  end

  // Round up when the remainder exceeds the root, then cap
  logic       up;
  logic [W:0] root_rnd;
  logic [W:0] cap;
  logic       sat_d;

  always_comb begin
    up       = rem_q[W-1] > (2*W)'(root_q[W-1]);
    root_rnd = {1'b0, root_q[W-1]} + (W+1)'(up);
    cap      = ((W+1)'(1) << (W - 2)) - (W+1)'(1);
    sat_d    = root_rnd > cap;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      dist_o <= sat_d ? cap[W-2:0] : root_rnd[W-2:0];
      sat_o  <= sat_d;
    end
  end

endmodule

// ----- rtl/ray_line_closest_distance_core.sv -----
// Top level of the ray and line closest-distance core: config registers, skid, pipeline.
// Depends on rlcd_pkg, rlcd_div and rlcd_sqrt.
//
//  channel  | direction | handshake               | payload
//  ---------+-----------+-------------------------+---------------------------------------
//  cfg      | in        | cfg_valid_i/cfg_ready_o | cfg_index_i, cfg_data_i
//  ray in   | in        | in_valid_i/in_ready_o   | ray_origin_{x,y,z}_i, ray_dir_{x,y,z}_i
//  result   | out       | out_valid_o/out_ready_i | closest_distance_o, axis_param_o, flags
//
// One ray enters every cycle while no result waits at the output; the bit-per-stage
// dividers and the bit-per-stage square root make up most of the pipeline depth.
// Reset clears the valid bits and the skid and loads the register defaults.
// A waiting result freezes the whole pipeline; a one-beat skid at the input still
// takes the next ray, so nothing is lost or repeated across a stall.
module ray_line_closest_distance_core #(
  parameter int unsigned COORD_WIDTH = 32,
  parameter int unsigned FRAC_BITS   = 16
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [rlcd_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [COORD_WIDTH-1:0]             cfg_data_i,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic signed [COORD_WIDTH-1:0]      ray_origin_x_i,
  input  logic signed [COORD_WIDTH-1:0]      ray_origin_y_i,
  input  logic signed [COORD_WIDTH-1:0]      ray_origin_z_i,
  input  logic signed [COORD_WIDTH-1:0]      ray_dir_x_i,
  input  logic signed [COORD_WIDTH-1:0]      ray_dir_y_i,
  input  logic signed [COORD_WIDTH-1:0]      ray_dir_z_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic [COORD_WIDTH-2:0]             closest_distance_o,
  output logic signed [COORD_WIDTH-1:0]      axis_param_o,
  output logic                               parallel_flag_o,
  output logic                               clamped_flag_o,
  output logic                               degenerate_flag_o
);

  localparam int unsigned W   = COORD_WIDTH;
  localparam int unsigned F   = FRAC_BITS;
  localparam int unsigned MW  = 2 * W + 1;       // product width
  localparam int unsigned PW  = 2 * W + F + 4;   // exact sum width before rounding
  localparam int unsigned LD  = W + F + 2;       // divider latency
  localparam int unsigned LS  = W + 1;           // square root latency
  localparam int unsigned LAT = 5 + LD + 1 + 4 + LS + 1;

  typedef struct packed {
    logic [2:0][W:0]   w0;
    logic [2:0][W-1:0] dr;
    logic              par;
    logic              czero;
    logic              ovf_base;
    logic              ovf_num;
  } side_t;

  typedef struct packed {
    logic [W-1:0] t;
    logic         par;
    logic         clamped;
    logic         ovf;
    logic         czero;
  } tail_t;

  // Round half away from zero from 2F to F fraction bits, saturate; returns {ovf, value}
  function automatic logic [W:0] narrow(input logic signed [PW-1:0] v);
    logic          neg;
    logic [PW-1:0] m;
    logic [PW-1:0] lim;
    logic          ovf;
    logic [W-1:0]  val;
    neg = v[PW-1];
    m   = neg ? (~v + PW'(1)) : v;
    m   = (m + (PW'(1) << (F - 1))) >> F;
    lim = neg ? (PW'(1) << (W - 1)) : ((PW'(1) << (W - 1)) - PW'(1));
    ovf = m > lim;
    if (ovf) begin
      m = lim;
    end
    val = neg ? W'(~m + PW'(1)) : W'(m);
    return {ovf, val};
  endfunction

  // ---------------------------------------------------------------- config registers
  logic signed [W-1:0] ao_q [3];
  logic signed [W-1:0] ad_q [3];
  logic [W-2:0]        eps_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ao_q[0] <= '0;
      ao_q[1] <= '0;
      ao_q[2] <= '0;
      ad_q[0] <= W'(64'(1) << F);
      ad_q[1] <= '0;
      ad_q[2] <= '0;
      eps_q   <= (W-1)'(1);
    end else if (cfg_valid_i) begin
      case (rlcd_pkg::cfg_reg_e'(cfg_index_i))
        rlcd_pkg::REG_AXIS_ORIGIN_X: ao_q[0] <= cfg_data_i;
        rlcd_pkg::REG_AXIS_ORIGIN_Y: ao_q[1] <= cfg_data_i;
        rlcd_pkg::REG_AXIS_ORIGIN_Z: ao_q[2] <= cfg_data_i;
        rlcd_pkg::REG_AXIS_DIR_X:    ad_q[0] <= cfg_data_i;
        rlcd_pkg::REG_AXIS_DIR_Y:    ad_q[1] <= cfg_data_i;
        rlcd_pkg::REG_AXIS_DIR_Z:    ad_q[2] <= cfg_data_i;
        rlcd_pkg::REG_PARALLEL_EPS:  eps_q   <= cfg_data_i[W-2:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------- skid and stall
  logic                pipe_en;
  logic [LAT-1:0]      vld_q;
  logic                skid_q;
  logic signed [W-1:0] skid_ro_q [3];
  logic signed [W-1:0] skid_dr_q [3];
  logic signed [W-1:0] ro_in [3];
  logic signed [W-1:0] dr_in [3];
  logic signed [W-1:0] ro_f  [3];
  logic signed [W-1:0] dr_f  [3];
  logic                front_vld;

  assign ro_in[0] = ray_origin_x_i;
  assign ro_in[1] = ray_origin_y_i;
  assign ro_in[2] = ray_origin_z_i;
  assign dr_in[0] = ray_dir_x_i;
  assign dr_in[1] = ray_dir_y_i;
  assign dr_in[2] = ray_dir_z_i;

  assign pipe_en    = !vld_q[LAT-1] || out_ready_i;
  assign in_ready_o = !skid_q;
  assign front_vld  = skid_q || in_valid_i;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      ro_f[k] = skid_q ? skid_ro_q[k] : ro_in[k];
      dr_f[k] = skid_q ? skid_dr_q[k] : dr_in[k];
    end
  end

  // Skid holds a beat that arrives while the pipeline is frozen
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      skid_q <= 1'b0;
    end else begin
      skid_q <= skid_q ? !pipe_en : (in_valid_i && !pipe_en);
    end
  end

  always_ff @(posedge clk_i) begin
    if (!skid_q && in_valid_i && !pipe_en) begin
      skid_ro_q <= ro_in;
      skid_dr_q <= dr_in;
    end
  end

  // Valid bits walk alongside the data
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (pipe_en) begin
      vld_q <= {vld_q[LAT-2:0], front_vld};
    end
  end

  // ---------------------------------------------------------------- stage 1: w0
  logic signed [W:0]   s1_w0_q [3];
  logic signed [W-1:0] s1_dr_q [3];

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      for (int k = 0; k < 3; k++) begin
        s1_w0_q[k] <= (W+1)'(ro_f[k]) - (W+1)'(ao_q[k]);
        s1_dr_q[k] <= dr_f[k];
      end
    end
  end

  // ---------------------------------------------------------------- stage 2: products
  // rows: a = dr.dr, b = dr.ad, c = ad.ad, d = dr.w0, e = ad.w0
  logic signed [MW-1:0] s2_p_q [5][3];
  logic signed [W:0]    s2_w0_q [3];
  logic signed [W-1:0]  s2_dr_q [3];

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      for (int k = 0; k < 3; k++) begin
        s2_p_q[0][k] <= MW'(s1_dr_q[k]) * MW'(s1_dr_q[k]);
        s2_p_q[1][k] <= MW'(s1_dr_q[k]) * MW'(ad_q[k]);
        s2_p_q[2][k] <= MW'(ad_q[k]) * MW'(ad_q[k]);
        s2_p_q[3][k] <= MW'(s1_dr_q[k]) * MW'(s1_w0_q[k]);
        s2_p_q[4][k] <= MW'(ad_q[k]) * MW'(s1_w0_q[k]);
      end
      s2_w0_q <= s1_w0_q;
      s2_dr_q <= s1_dr_q;
    end
  end

  // ---------------------------------------------------------------- stage 3: dot products
  logic signed [W-1:0] s3_dot_q [5];
  logic                s3_ovf_q;
  logic signed [W:0]   s3_w0_q [3];
  logic signed [W-1:0] s3_dr_q [3];
  logic signed [W-1:0] dot_d [5];
  logic                ovf3_d;

  always_comb begin
    logic [W:0] nr;
    ovf3_d = 1'b0;
    for (int j = 0; j < 5; j++) begin
      nr       = narrow(PW'(s2_p_q[j][0]) + PW'(s2_p_q[j][1]) + PW'(s2_p_q[j][2]));
      dot_d[j] = nr[W-1:0];
      ovf3_d   = ovf3_d | nr[W];
    end
  end

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      s3_dot_q <= dot_d;
      s3_ovf_q <= ovf3_d;
      s3_w0_q  <= s2_w0_q;
      s3_dr_q  <= s2_dr_q;
    end
  end

  // ---------------------------------------------------------------- stage 4: cross products
  logic signed [MW-1:0] s4_ac_q, s4_bb_q, s4_be_q, s4_cd_q, s4_ae_q, s4_bd_q;
  logic signed [W-1:0]  s4_e_q, s4_c_q;
  logic                 s4_czero_q;
  logic                 s4_ovf_q;
  logic signed [W:0]    s4_w0_q [3];
  logic signed [W-1:0]  s4_dr_q [3];

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      s4_ac_q    <= MW'(s3_dot_q[0]) * MW'(s3_dot_q[2]);
      s4_bb_q    <= MW'(s3_dot_q[1]) * MW'(s3_dot_q[1]);
      s4_be_q    <= MW'(s3_dot_q[1]) * MW'(s3_dot_q[4]);
      s4_cd_q    <= MW'(s3_dot_q[2]) * MW'(s3_dot_q[3]);
      s4_ae_q    <= MW'(s3_dot_q[0]) * MW'(s3_dot_q[4]);
      s4_bd_q    <= MW'(s3_dot_q[1]) * MW'(s3_dot_q[3]);
      s4_e_q     <= s3_dot_q[4];
      s4_c_q     <= s3_dot_q[2];
      s4_czero_q <= s3_dot_q[2] == '0;
      s4_ovf_q   <= s3_ovf_q;
      s4_w0_q    <= s3_w0_q;
      s4_dr_q    <= s3_dr_q;
    end
  end

  // ---------------------------------------------------------------- stage 5: den, numerators
  logic signed [W-1:0] s5_den_q, s5_ns_q, s5_nt_q, s5_e_q, s5_c_q;
  logic                s5_czero_q, s5_ovf_base_q, s5_ovf_num_q;
  logic signed [W:0]   s5_w0_q [3];
  logic signed [W-1:0] s5_dr_q [3];
  logic [W:0]          den_n, ns_n, nt_n;

  always_comb begin
    den_n = narrow(PW'(s4_ac_q) - PW'(s4_bb_q));
    ns_n  = narrow(PW'(s4_be_q) - PW'(s4_cd_q));
    nt_n  = narrow(PW'(s4_ae_q) - PW'(s4_bd_q));
  end

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      s5_den_q      <= den_n[W-1:0];
      s5_ns_q       <= ns_n[W-1:0];
      s5_nt_q       <= nt_n[W-1:0];
      s5_e_q        <= s4_e_q;
      s5_c_q        <= s4_c_q;
      s5_czero_q    <= s4_czero_q;
      s5_ovf_base_q <= s4_ovf_q | den_n[W];
      s5_ovf_num_q  <= ns_n[W] | nt_n[W];
      s5_w0_q       <= s4_w0_q;
      s5_dr_q       <= s4_dr_q;
    end
  end

  // ---------------------------------------------------------------- dividers
  logic [W-1:0] den_mag;
  logic         par5;

  assign den_mag = s5_den_q[W-1] ? (~s5_den_q + W'(1)) : s5_den_q;
  assign par5    = (s5_den_q == '0) || (den_mag < {1'b0, eps_q});

  logic signed [W-1:0] s_quot, t_quot, ec_quot;
  rlcd_pkg::div_stat_t s_stat, t_stat, ec_stat;

  rlcd_div #(.COORD_WIDTH(W), .FRAC_BITS(F)) u_div_s (
    .clk_i (clk_i), .en_i (pipe_en), .num_i (s5_ns_q), .den_i (s5_den_q),
    .quot_o(s_quot), .stat_o(s_stat)
  );

  rlcd_div #(.COORD_WIDTH(W), .FRAC_BITS(F)) u_div_t (
    .clk_i (clk_i), .en_i (pipe_en), .num_i (s5_nt_q), .den_i (s5_den_q),
    .quot_o(t_quot), .stat_o(t_stat)
  );

  rlcd_div #(.COORD_WIDTH(W), .FRAC_BITS(F)) u_div_ec (
    .clk_i (clk_i), .en_i (pipe_en), .num_i (s5_e_q), .den_i (s5_c_q),
    .quot_o(ec_quot), .stat_o(ec_stat)
  );

  // Side data delayed to match the divider latency
  side_t side_d;
  side_t side_q [LD];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      side_d.w0[k] = s5_w0_q[k];
      side_d.dr[k] = s5_dr_q[k];
    end
    side_d.par      = par5;
    side_d.czero    = s5_czero_q;
    side_d.ovf_base = s5_ovf_base_q;
    side_d.ovf_num  = s5_ovf_num_q;
  end

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      side_q[0] <= side_d;
      for (int i = 1; i < LD; i++) begin
        side_q[i] <= side_q[i-1];
      end
    end
  end

  // ---------------------------------------------------------------- select s and t
  side_t               sd;
  logic                take_ec;
  logic                ovf_sel;
  logic signed [W-1:0] sD_s_q;
  logic signed [W:0]   sD_w0_q [3];
  logic signed [W-1:0] sD_dr_q [3];
  tail_t               sD_tail_q;

  assign sd      = side_q[LD-1];
  assign take_ec = sd.par || s_stat.neg;
  assign ovf_sel = sd.ovf_base | (sd.par ? ec_stat.ovf
                 : (sd.ovf_num | s_stat.ovf | t_stat.ovf | (s_stat.neg & ec_stat.ovf)));

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      sD_s_q            <= take_ec ? '0 : s_quot;
      sD_tail_q.t       <= take_ec ? ec_quot : t_quot;
      sD_tail_q.par     <= sd.par;
      sD_tail_q.clamped <= !sd.par && s_stat.neg;
      sD_tail_q.ovf     <= ovf_sel;
      sD_tail_q.czero   <= sd.czero;
      for (int k = 0; k < 3; k++) begin
        sD_w0_q[k] <= sd.w0[k];
        sD_dr_q[k] <= sd.dr[k];
      end
    end
  end

  // ---------------------------------------------------------------- M1: point products
  logic signed [MW-1:0] m1_ds_q [3];
  logic signed [MW-1:0] m1_at_q [3];
  logic signed [W:0]    m1_w0_q [3];
  tail_t                m1_tail_q;

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      for (int k = 0; k < 3; k++) begin
        m1_ds_q[k] <= MW'(sD_dr_q[k]) * MW'(sD_s_q);
        m1_at_q[k] <= MW'(ad_q[k]) * MW'($signed(sD_tail_q.t));
      end
      m1_w0_q   <= sD_w0_q;
      m1_tail_q <= sD_tail_q;
    end
  end

  // ---------------------------------------------------------------- M2: difference vector
  logic signed [W-1:0] m2_df_q [3];
  tail_t               m2_tail_q;
  logic signed [W-1:0] df_d [3];
  logic                ovf_m2;

  always_comb begin
    logic [W:0] nr;
    ovf_m2 = m1_tail_q.ovf;
    for (int k = 0; k < 3; k++) begin
      nr      = narrow((PW'(m1_w0_q[k]) <<< F) + PW'(m1_ds_q[k]) - PW'(m1_at_q[k]));
      df_d[k] = nr[W-1:0];
      ovf_m2  = ovf_m2 | nr[W];
    end
  end

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      m2_df_q   <= df_d;
      m2_tail_q <= '{t: m1_tail_q.t, par: m1_tail_q.par, clamped: m1_tail_q.clamped,
                     ovf: ovf_m2, czero: m1_tail_q.czero};
    end
  end

  // ---------------------------------------------------------------- Q1: squares
  logic [2*W-1:0] q1_sq_q [3];
  tail_t          q1_tail_q;
  logic [W-1:0]   df_mag [3];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      df_mag[k] = m2_df_q[k][W-1] ? (~m2_df_q[k] + W'(1)) : m2_df_q[k];
    end
  end

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      for (int k = 0; k < 3; k++) begin
        q1_sq_q[k] <= (2*W)'(df_mag[k]) * (2*W)'(df_mag[k]);
      end
      q1_tail_q <= m2_tail_q;
    end
  end

  // ---------------------------------------------------------------- Q2: squared distance
  logic [2*W-1:0] q2_sum_q;
  tail_t          q2_tail_q;

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      q2_sum_q  <= q1_sq_q[0] + q1_sq_q[1] + q1_sq_q[2];
      q2_tail_q <= q1_tail_q;
    end
  end

  // ---------------------------------------------------------------- square root
  logic [W-2:0] root_dist;
  logic         root_sat;
  tail_t        tail_q [LS];

  rlcd_sqrt #(.COORD_WIDTH(W)) u_sqrt (
    .clk_i (clk_i), .en_i (pipe_en), .sq_i (q2_sum_q),
    .dist_o(root_dist), .sat_o(root_sat)
  );

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      tail_q[0] <= q2_tail_q;
      for (int i = 1; i < LS; i++) begin
        tail_q[i] <= tail_q[i-1];
      end
    end
  end

  // ---------------------------------------------------------------- output register
  tail_t tl;
  logic  out_czero_q;

  assign tl = tail_q[LS-1];

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      out_czero_q <= tl.czero;
      if (tl.czero) begin
        // zero-length axis: everything saturated
        closest_distance_o <= ((W-1)'(1) << (W - 2)) - (W-1)'(1);
        axis_param_o       <= (W'(1) << (W - 1)) - W'(1);
        parallel_flag_o    <= 1'b1;
        clamped_flag_o     <= 1'b0;
        degenerate_flag_o  <= 1'b1;
      end else begin
        closest_distance_o <= root_dist;
        axis_param_o       <= tl.t;
        parallel_flag_o    <= tl.par;
        clamped_flag_o     <= tl.clamped;
        degenerate_flag_o  <= tl.ovf | root_sat;
      end
    end
  end

  assign out_valid_o = vld_q[LAT-1];

`ifndef NO_ASSERTIONS
  // A frozen pipeline keeps its valid bits
  a_freeze: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !pipe_en |=> $stable(vld_q))
    else $error("valid bits moved while the pipeline was frozen");

  // The skid only fills from a beat taken during a freeze
  a_skid_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(skid_q) |-> $past(!pipe_en && in_valid_i))
    else $error("skid filled without a stalled input beat");

  // Parallel and clamped are exclusive
  a_flags: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(parallel_flag_o && clamped_flag_o))
    else $error("parallel and clamped flags both set");

  // Zero-length axis result carries its flags
  a_czero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_czero_q) |-> (parallel_flag_o && degenerate_flag_o))
    else $error("zero-length axis result without its flags");
`endif

endmodule

// ----- sim/tb_top.sv -----
// Self-checking testbench for ray_line_closest_distance_core: a queue-fed driver,
// a bit-exact fixed-point predictor and a monitor. Depends on rlcd_pkg and the core RTL.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CW        = 32;
  localparam int unsigned FB        = 16;
  localparam int unsigned DRAIN_CYC = 2*CW + FB + 40;
  localparam int unsigned WDOG_MAX  = 4000;
  localparam int unsigned HOLD_CYC  = 400;
  localparam logic [rlcd_pkg::CFG_IDX_W-1:0] CFG_IDX_SPARE = 3'd7;

  typedef logic signed [127:0] wide_t;

  typedef struct {
    logic signed [CW-1:0] org[3];
    logic signed [CW-1:0] dir[3];
  } ray_t;

  typedef struct {
    logic [CW-2:0]        dist_len;
    logic signed [CW-1:0] tpar;
    logic                 par;
    logic                 clp;
    logic                 deg;
  } hit_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [rlcd_pkg::CFG_IDX_W-1:0] cfg_index_i = '0;
  logic [CW-1:0] cfg_data_i = '0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic signed [CW-1:0] ray_origin_x_i = '0, ray_origin_y_i = '0, ray_origin_z_i = '0;
  logic signed [CW-1:0] ray_dir_x_i = '0, ray_dir_y_i = '0, ray_dir_z_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic [CW-2:0] closest_distance_o;
  logic signed [CW-1:0] axis_param_o;
  logic parallel_flag_o, clamped_flag_o, degenerate_flag_o;

  ray_t pending_rays[$];
  hit_t expected_hits[$];

  // predictor copy of the line registers
  logic signed [CW-1:0] line_org[3];
  logic signed [CW-1:0] line_dir[3];
  logic [CW-2:0]        line_eps;

  int unsigned send_idle = 0;
  int unsigned recv_stall = 0;
  bit hold_req = 0, hold_done = 0;
  int unsigned hold_cnt = 0;
  bit in_fire = 0;
  int unsigned cfg_beats = 0;
  int unsigned mismatches = 0;
  int unsigned idle_cycles = 0;

  ray_line_closest_distance_core #(.COORD_WIDTH(CW), .FRAC_BITS(FB)) u_top (.*);

  always #5 clk_i = ~clk_i;

  // ---------------- fixed-point predictor ----------------
  function automatic wide_t fx_sat(wide_t m, bit ng, inout bit ovf);
    wide_t lim;
    lim = ng ? (wide_t'(1) <<< (CW-1)) : ((wide_t'(1) <<< (CW-1)) - 1);
    if (m > lim) begin
      ovf = 1;
      m = lim;
    end
    return ng ? -m : m;
  endfunction

  // round a 2*FB fraction sum to FB bits, ties away from zero, then saturate
  function automatic wide_t fx_round(wide_t v, inout bit ovf);
    wide_t m;
    bit ng;
    ng = v < 0;
    m = ng ? -v : v;
    m = (m + (wide_t'(1) <<< (FB-1))) >>> FB;
    return fx_sat(m, ng, ovf);
  endfunction

  function automatic wide_t fx_div(wide_t num, wide_t den, inout bit ovf);
    wide_t n, dd, q, rm;
    n = (num < 0 ? -num : num) <<< FB;
    dd = den < 0 ? -den : den;
    q = n / dd;
    rm = n % dd;
    if (rm >= dd - rm) q = q + 1;
    return fx_sat(q, (num < 0) != (den < 0), ovf);
  endfunction

  function automatic wide_t fx_dot(wide_t x[3], wide_t y[3], inout bit ovf);
    return fx_round(x[0]*y[0] + x[1]*y[1] + x[2]*y[2], ovf);
  endfunction

  function automatic hit_t closest_hit(ray_t ry);
    wide_t ro[3], dr[3], ao[3], ad[3], w0[3], df;
    wide_t a, b, c, d, e, den, s, t, sq, r, cand;
    bit ovf, par, clp;
    hit_t h;
    ovf = 0;
    clp = 0;
    sq = 0;
    for (int k = 0; k < 3; k++) begin
      ro[k] = wide_t'(ry.org[k]);
      dr[k] = wide_t'(ry.dir[k]);
      ao[k] = wide_t'(line_org[k]);
      ad[k] = wide_t'(line_dir[k]);
      w0[k] = ro[k] - ao[k];
    end
    a = fx_dot(dr, dr, ovf);
    b = fx_dot(dr, ad, ovf);
    c = fx_dot(ad, ad, ovf);
    d = fx_dot(dr, w0, ovf);
    e = fx_dot(ad, w0, ovf);
    // zero-length axis: everything saturated
    if (c == 0) begin
      h.dist_len = (1 << (CW-2)) - 1;
      h.tpar = {1'b0, {(CW-1){1'b1}}};
      h.par = 1;
      h.clp = 0;
      h.deg = 1;
      return h;
    end
    den = fx_round(a*c - b*b, ovf);
    par = (den == 0) || ((den < 0 ? -den : den) < wide_t'(line_eps));
    if (par) begin
      s = 0;
      t = fx_div(e, c, ovf);
    end else begin
      s = fx_div(fx_round(b*e - c*d, ovf), den, ovf);
      t = fx_div(fx_round(a*e - b*d, ovf), den, ovf);
      if (s < 0) begin
        s = 0;
        t = fx_div(e, c, ovf);
        clp = 1;
      end
    end
    for (int k = 0; k < 3; k++) begin
      df = fx_round((w0[k] <<< FB) + dr[k]*s - ad[k]*t, ovf);
      sq = sq + df*df;
    end
    // integer square root, rounded to nearest
    r = 0;
    for (int k = 48; k >= 0; k--) begin
      cand = r | (wide_t'(1) <<< k);
      if (cand*cand <= sq) r = cand;
    end
    if (sq - r*r > r) r = r + 1;
    if (r > wide_t'((1 << (CW-2)) - 1)) begin
      r = (1 << (CW-2)) - 1;
      ovf = 1;
    end
    h.dist_len = r[CW-2:0];
    h.tpar = t[CW-1:0];
    h.par = par;
    h.clp = clp;
    h.deg = ovf;
    return h;
  endfunction

  // ---------------- monitor: accepts, config shadow, checking ----------------
  always @(posedge clk_i or negedge rst_ni) begin
    hit_t want;
    if (!rst_ni) begin
      line_org[0] <= '0; line_org[1] <= '0; line_org[2] <= '0;
      line_dir[0] <= 1 << FB; line_dir[1] <= '0; line_dir[2] <= '0;
      line_eps <= 1;
      in_fire <= 0;
    end else begin
      in_fire <= in_valid_i && in_ready_o;
      if (cfg_valid_i && cfg_ready_o) begin
        cfg_beats <= cfg_beats + 1;
        case (cfg_index_i)
          rlcd_pkg::REG_AXIS_ORIGIN_X: line_org[0] <= cfg_data_i;
          rlcd_pkg::REG_AXIS_ORIGIN_Y: line_org[1] <= cfg_data_i;
          rlcd_pkg::REG_AXIS_ORIGIN_Z: line_org[2] <= cfg_data_i;
          rlcd_pkg::REG_AXIS_DIR_X:    line_dir[0] <= cfg_data_i;
          rlcd_pkg::REG_AXIS_DIR_Y:    line_dir[1] <= cfg_data_i;
          rlcd_pkg::REG_AXIS_DIR_Z:    line_dir[2] <= cfg_data_i;
          rlcd_pkg::REG_PARALLEL_EPS:  line_eps <= cfg_data_i[CW-2:0];
          default: ;
        endcase
      end
      if (in_valid_i && in_ready_o) begin
        ray_t ry;
        ry.org[0] = ray_origin_x_i; ry.org[1] = ray_origin_y_i; ry.org[2] = ray_origin_z_i;
        ry.dir[0] = ray_dir_x_i; ry.dir[1] = ray_dir_y_i; ry.dir[2] = ray_dir_z_i;
        expected_hits.push_back(closest_hit(ry));
      end
      if (out_valid_o && out_ready_i) begin
        if (expected_hits.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result beat: dist %h t %h",
                                         closest_distance_o, axis_param_o);
        end else begin
          want = expected_hits.pop_front();
          if (want.dist_len !== closest_distance_o || want.tpar !== axis_param_o ||
              want.par !== parallel_flag_o || want.clp !== clamped_flag_o ||
              want.deg !== degenerate_flag_o) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: exp dist %h t %h p%b c%b d%b / got dist %h t %h p%b c%b d%b",
                       want.dist_len, want.tpar, want.par, want.clp, want.deg,
                       closest_distance_o, axis_param_o, parallel_flag_o,
                       clamped_flag_o, degenerate_flag_o);
          end
        end
      end
      // watchdog on cycles without any beat while rays or results are outstanding
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
          (cfg_valid_i && cfg_ready_o) || !in_valid_i && expected_hits.size() == 0)
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WDOG_MAX) begin
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  // ---------------- driver: ray beats ----------------
  always @(negedge clk_i) begin
    ray_t ry;
    if (rst_ni && (!in_valid_i || in_fire)) begin
      if (pending_rays.size() > 0 && $urandom_range(0, 99) >= send_idle) begin
        ry = pending_rays.pop_front();
        ray_origin_x_i <= ry.org[0]; ray_origin_y_i <= ry.org[1]; ray_origin_z_i <= ry.org[2];
        ray_dir_x_i <= ry.dir[0]; ray_dir_y_i <= ry.dir[1]; ray_dir_z_i <= ry.dir[2];
        in_valid_i <= 1'b1;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // ---------------- receiver: back-pressure and long hold-off ----------------
  always @(negedge clk_i) begin
    if (hold_req && !hold_done) begin
      hold_done <= 1;
      hold_cnt <= HOLD_CYC;
      out_ready_i <= 1'b0;
    end else if (hold_cnt > 0) begin
      hold_cnt <= hold_cnt - 1;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= rst_ni && ($urandom_range(0, 99) >= recv_stall);
    end
  end

  // ---------------- stimulus ----------------
  function automatic logic signed [CW-1:0] rand_coord();
    case ($urandom_range(0, 9))
      0: case ($urandom_range(0, 5))
           0: return {1'b1, {(CW-1){1'b0}}};
           1: return {1'b0, {(CW-1){1'b1}}};
           2: return 0;
           3: return -1;
           4: return 1;
           default: return 1 << FB;
         endcase
      1, 2: return $urandom;
      default: return $signed($urandom_range(0, 1 << 21)) - (1 << 20);
    endcase
  endfunction

  task automatic add_ray(input logic signed [CW-1:0] ox, oy, oz, dx, dy, dz);
    ray_t ry;
    ry.org[0] = ox; ry.org[1] = oy; ry.org[2] = oz;
    ry.dir[0] = dx; ry.dir[1] = dy; ry.dir[2] = dz;
    pending_rays.push_back(ry);
  endtask

  task automatic add_random_rays(input int unsigned n);
    ray_t ry;
    int sel;
    for (int unsigned i = 0; i < n; i++) begin
      for (int k = 0; k < 3; k++) begin
        ry.org[k] = rand_coord();
        ry.dir[k] = rand_coord();
      end
      sel = $urandom_range(0, 19);
      // a few rays along the line, or with no direction at all
      if (sel < 2) for (int k = 0; k < 3; k++) ry.dir[k] = sel ? line_dir[k] : -line_dir[k];
      else if (sel == 2) for (int k = 0; k < 3; k++) ry.dir[k] = 0;
      pending_rays.push_back(ry);
    end
  endtask

  task automatic cfg_write(input logic [rlcd_pkg::CFG_IDX_W-1:0] idx,
                           input logic [CW-1:0] data);
    int unsigned seen;
    @(negedge clk_i);
    seen = cfg_beats;
    cfg_index_i = idx;
    cfg_data_i = data;
    cfg_valid_i = 1'b1;
    do @(negedge clk_i); while (cfg_beats == seen);
    cfg_valid_i = 1'b0;
  endtask

  task automatic set_line(input logic [CW-1:0] ox, oy, oz, dx, dy, dz, eps);
    cfg_write(rlcd_pkg::REG_AXIS_ORIGIN_X, ox);
    cfg_write(rlcd_pkg::REG_AXIS_ORIGIN_Y, oy);
    cfg_write(rlcd_pkg::REG_AXIS_ORIGIN_Z, oz);
    cfg_write(rlcd_pkg::REG_AXIS_DIR_X, dx);
    cfg_write(rlcd_pkg::REG_AXIS_DIR_Y, dy);
    cfg_write(rlcd_pkg::REG_AXIS_DIR_Z, dz);
    cfg_write(rlcd_pkg::REG_PARALLEL_EPS, eps);
    cfg_write(CFG_IDX_SPARE, $urandom);
  endtask

  task automatic drain();
    while (pending_rays.size() > 0 || in_valid_i || expected_hits.size() > 0)
      @(posedge clk_i);
    repeat (DRAIN_CYC) @(posedge clk_i);
  endtask

  initial begin
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed rays against the reset line (x axis)
    add_ray(0, 0, 0, 0, 0, 0);
    add_ray(0, 1 << FB, 0, 0, 0, 1 << FB);
    add_ray(0, 1 << FB, 0, 1 << FB, 0, 0);
    add_ray(0, 1 << FB, 0, -(1 << FB), 0, 0);
    add_ray(0, 2 << FB, 0, 0, 1 << FB, 0);
    add_ray(0, 2 << FB, 0, 0, -(1 << FB), 0);
    add_ray(5 << FB, 3 << FB, 4 << FB, 1 << FB, 1 << FB, 0);
    add_ray(32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff);
    add_ray(32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000);
    add_ray(32'h7fffffff, 32'h80000000, 0, 1, -1, 1);
    add_ray(1, -1, 1, 32'h80000000, 32'h7fffffff, 32'h80000000);
    add_ray(0, 0, 1 << FB, 1, 0, 1);
    add_ray(-1, -1, -1, -1, -1, -1);
    add_ray(100 << FB, -7 << FB, 3 << FB, 0, 0, 32'h7fffffff);
    add_random_rays(260);
    drain();

    send_idle = 78;
    set_line(3 << FB, -2 << FB, 1 << FB, 1 << FB, 2 << FB, -(1 << FB), 1 << FB);
    add_random_rays(270);
    drain();

    send_idle = 0;
    recv_stall = 78;
    set_line($urandom_range(0, 1 << 20), -(5 << FB), 0, 0, 1 << FB, 1 << FB, 0);
    hold_req = 1;
    add_random_rays(270);
    drain();

    send_idle = 23;
    recv_stall = 23;
    set_line(32'h7fffffff, 32'h80000000, 32'h7fffffff, 32'h80000000, 32'h7fffffff, 1,
             32'h7fffffff);
    add_random_rays(260);
    drain();

    send_idle = 0;
    recv_stall = 0;
    set_line($urandom, $urandom, $urandom, $urandom_range(0, 1 << 19),
             $urandom_range(0, 1 << 19), 0, $urandom);
    add_random_rays(270);
    drain();

    // zero-length axis, then one too short to survive rounding
    recv_stall = 23;
    set_line(0, 0, 0, 0, 0, 0, 32'hffffffff);
    add_random_rays(150);
    drain();
    send_idle = 23;
    set_line(1 << FB, 0, 0, 1, 1, -1, 0);
    add_random_rays(120);
    drain();

    send_idle = 78;
    recv_stall = 78;
    set_line($urandom_range(0, 1 << 21), $urandom_range(0, 1 << 21), 0,
             -(1 << FB), 0, 3 << FB, 1 << 10);
    add_random_rays(260);
    drain();

    if (mismatches == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end

endmodule
